### rtl/core/lpse_pkg.sv
package lpse_pkg;

  localparam int unsigned MaxPixels = 16;
  localparam int unsigned PixAw     = $clog2(MaxPixels);
  localparam int unsigned CntW      = 5;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 72;

  localparam logic [7:0] ByteZero = 8'hE0;
  localparam logic [7:0] ByteOne  = 8'hF8;

  localparam logic [1:0] GrpGreen = 2'd0;
  localparam logic [1:0] GrpRed   = 2'd1;
  localparam logic [1:0] GrpBlue  = 2'd2;

  typedef enum logic [2:0] {
    ModeSetHex    = 3'd0,
    ModeSetParts  = 3'd1,
    ModeFillRaw   = 3'd2,
    ModeFillParts = 3'd3,
    ModeShow      = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0]       bits;
    logic [PixAw-1:0] pixel;
    logic [1:0]       group;
    logic             last;
  } grp_item_t;

  function automatic logic [63:0] encode_group(logic [7:0] bits8);
    logic [63:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[8*k +: 8] = bits8[k] ? ByteOne : ByteZero;
    end
    return w;
  endfunction

endpackage

### rtl/core/lpse_ram.sv
module lpse_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lpse_out.sv
module lpse_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  lpse_pkg::grp_item_t                 in_item_i,
  output logic                                in_ready_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [lpse_pkg::OutDataW-1:0]       m_axis_tdata_o, // spi_bytes, pixel_number, group_number
  output logic                                m_axis_tlast_o
);

  logic                         valid_q, valid_d;
  logic [63:0]                  bytes_q;
  logic [3:0]                   pixel_q;
  logic [1:0]                   group_q;
  logic                         last_q;
  logic                         load;

  assign in_ready_o = !valid_q || m_axis_tready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (m_axis_tready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= lpse_pkg::encode_group(in_item_i.bits);
      pixel_q <= 4'(in_item_i.pixel);
      group_q <= in_item_i.group;
      last_q  <= in_item_i.last;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(lpse_pkg::OutDataW - 70){1'b0}}, group_q, pixel_q, bytes_q};
  assign m_axis_tlast_o  = last_q;

endmodule

### rtl/core/led_pixel_store_spi_encoder_top.sv
// a set item is taken while idle; a fill holds input ready low while it writes each active pixel
// show: for each pixel one read of the single store port, then its green, red and blue items,
// each held until the output stage takes it; input ready stays low until the last is taken
// reset: pixel_count returns to 1 and all store entries read as zero at once
// (a valid bit per entry, no clearing pass)
module led_pixel_store_spi_encoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lpse_pkg::CntW-1:0]           cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [lpse_pkg::InDataW-1:0]        s_axis_tdata_i, // pixel_index, color_word, red, green, blue
  input  logic [2:0]                          s_axis_tuser_i, // mode
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [lpse_pkg::OutDataW-1:0]       m_axis_tdata_o, // spi_bytes, pixel_number, group_number
  output logic                                m_axis_tlast_o
);

  typedef enum logic [1:0] {
    StIdle,
    StFill,
    StShowRd,
    StShowEmit
  } state_e;

  localparam int unsigned PixAw = lpse_pkg::PixAw;
  localparam int unsigned CntW  = lpse_pkg::CntW;

  state_e                          state_q, state_d;
  logic [CntW-1:0]                 cnt_q;
  logic [CntW-1:0]                 n_act;
  logic [PixAw-1:0]                pix_q, pix_d;
  logic [1:0]                      grp_q, grp_d;
  logic [lpse_pkg::ColorW-1:0]     fill_q, fill_d;
  logic [lpse_pkg::MaxPixels-1:0]  valid_q;
  logic                            vld_rd_q, vld_rd_d;

  logic                            accept;
  logic [7:0]                      idx;
  logic [23:0]                     word;
  logic [7:0]                      red, green, blue;
  logic                            set_hit;
  logic                            last_pix;

  logic                            we;
  logic [PixAw-1:0]                waddr;
  logic [lpse_pkg::ColorW-1:0]     wdata;
  logic                            re;
  logic [lpse_pkg::ColorW-1:0]     rdata;
  logic [lpse_pkg::ColorW-1:0]     pix_word;

  logic                            item_valid, item_ready;
  lpse_pkg::grp_item_t             item;

  assign cfg_ready_o = 1'b1;

  assign n_act = (cnt_q > CntW'(lpse_pkg::MaxPixels)) ? CntW'(lpse_pkg::MaxPixels) : cnt_q;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign idx             = s_axis_tdata_i[7:0];
  assign word            = s_axis_tdata_i[31:8];
  assign red             = s_axis_tdata_i[39:32];
  assign green           = s_axis_tdata_i[47:40];
  assign blue            = s_axis_tdata_i[55:48];
  assign set_hit         = idx < 8'(n_act);
  assign last_pix        = (CntW'(pix_q) + CntW'(1)) == n_act;

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = idx[PixAw-1:0];
    wdata = {green, red, blue};
    if (state_q == StFill) begin
      we    = 1'b1;
      waddr = pix_q;
      wdata = fill_q;
    end else if (accept) begin
      unique case (s_axis_tuser_i)
        lpse_pkg::ModeSetHex: begin
          we    = set_hit;
          wdata = {word[15:8], word[23:16], word[7:0]};
        end
        lpse_pkg::ModeSetParts: begin
          we    = set_hit;
        end
        default: begin
          we    = 1'b0;
        end
      endcase
    end
  end

  assign re       = (state_q == StShowRd);
  assign pix_word = vld_rd_q ? rdata : '0;

  always_comb begin
    item.pixel = pix_q;
    item.group = grp_q;
    item.last  = last_pix && (grp_q == lpse_pkg::GrpBlue);
    case (grp_q)
      lpse_pkg::GrpGreen: item.bits = pix_word[23:16];
      lpse_pkg::GrpRed:   item.bits = pix_word[15:8];
      default:            item.bits = pix_word[7:0];
    endcase
  end

  assign item_valid = (state_q == StShowEmit);

  always_comb begin
    state_d  = state_q;
    pix_d    = pix_q;
    grp_d    = grp_q;
    fill_d   = fill_q;
    vld_rd_d = vld_rd_q;
    unique case (state_q)
      StIdle: begin
        pix_d = '0;
        grp_d = lpse_pkg::GrpGreen;
        if (accept && (n_act != '0)) begin
          unique case (s_axis_tuser_i)
            lpse_pkg::ModeFillRaw: begin
              fill_d  = word;
              state_d = StFill;
            end
            lpse_pkg::ModeFillParts: begin
              fill_d  = {green, red, blue};
              state_d = StFill;
            end
            lpse_pkg::ModeShow: begin
              state_d = StShowRd;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StFill: begin
        pix_d = pix_q + PixAw'(1);
        if (last_pix) begin
          state_d = StIdle;
        end
      end
      StShowRd: begin
        vld_rd_d = valid_q[pix_q];
        grp_d    = lpse_pkg::GrpGreen;
        state_d  = StShowEmit;
      end
      StShowEmit: begin
        if (item_ready) begin
          if (grp_q == lpse_pkg::GrpBlue) begin
            pix_d   = pix_q + PixAw'(1);
            state_d = last_pix ? StIdle : StShowRd;
          end else begin
            grp_d = grp_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= CntW'(1);
      pix_q    <= '0;
      grp_q    <= lpse_pkg::GrpGreen;
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pix_q    <= pix_d;
      grp_q    <= grp_d;
      vld_rd_q <= vld_rd_d;
      if (cfg_valid_i) begin
        cnt_q <= cfg_data_i;
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
  end

  lpse_ram #(
    .Width (lpse_pkg::ColorW),
    .Depth (lpse_pkg::MaxPixels)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (pix_q),
    .rdata_o (rdata)
  );

  lpse_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (item_valid),
    .in_item_i       (item),
    .in_ready_o      (item_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### rtl/core/lpse_checker.sv
module lpse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [lpse_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output item changed while stalled");

  a_group_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[69:68] != 2'd3)
    else $error("group number out of range");

  a_last_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[69:68] == lpse_pkg::GrpBlue)
    else $error("last item is not the blue group");

  a_busy_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input accepted in the middle of a show");

  a_byte_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[63:56] == lpse_pkg::ByteZero || m_axis_tdata_o[63:56] == lpse_pkg::ByteOne)
      && (m_axis_tdata_o[7:0] == lpse_pkg::ByteZero || m_axis_tdata_o[7:0] == lpse_pkg::ByteOne))
    else $error("spi byte is not a bit code");

endmodule

bind led_pixel_store_spi_encoder_top lpse_checker u_lpse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned TailCycles = 80;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned NumPhases  = 9;

  localparam logic [2:0] ModeUnused5 = 3'd5;
  localparam logic [2:0] ModeUnused6 = 3'd6;
  localparam logic [2:0] ModeUnused7 = 3'd7;

  localparam logic [63:0] AllZero = {8{lpse_pkg::ByteZero}};
  localparam logic [63:0] AllOne  = {8{lpse_pkg::ByteOne}};

  typedef enum bit {RowOp, RowCount} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [4:0]  count;
    logic [2:0]  mode;
    logic [7:0]  idx;
    logic [23:0] word;
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;
    bit          typed;
    logic [63:0] exp_g;
    logic [63:0] exp_r;
    logic [63:0] exp_b;
  } step_t;

  typedef struct {
    logic [63:0] spi;
    logic [3:0]  pixel;
    logic [1:0]  group;
    logic        last;
  } spi_group_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [lpse_pkg::CntW-1:0]     cfg_data_i;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [lpse_pkg::InDataW-1:0]  s_axis_tdata_i;  // pixel_index, color_word, red, green, blue
  logic [2:0]                    s_axis_tuser_i;  // mode
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [lpse_pkg::OutDataW-1:0] m_axis_tdata_o;  // spi_bytes, pixel_number, group_number
  logic                          m_axis_tlast_o;

  led_pixel_store_spi_encoder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  logic [lpse_pkg::ColorW-1:0] grb_store [lpse_pkg::MaxPixels];
  logic [lpse_pkg::CntW-1:0]   count_reg;
  spi_group_t                  spi_words_due [$];

  int unsigned n_items;
  int unsigned n_shows;
  int unsigned n_results;
  int unsigned n_counts;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned sink_wait;
  bit          calm;
  bit          pressure_req;
  bit          pressure_done;

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int unsigned lit_pixels();
    return (32'(count_reg) > lpse_pkg::MaxPixels) ? lpse_pkg::MaxPixels : 32'(count_reg);
  endfunction

  function automatic logic [63:0] spi_word(input logic [7:0] bits8);
    logic [63:0] w;
    w = '0;
    for (int k = 7; k >= 0; k--) begin
      w = {w[55:0], bits8[k] ? lpse_pkg::ByteOne : lpse_pkg::ByteZero};
    end
    return w;
  endfunction

  function automatic step_t op_row(input logic [2:0] mode, input logic [7:0] idx,
                                   input logic [23:0] word, input logic [7:0] red,
                                   input logic [7:0] grn, input logic [7:0] blu);
    step_t s;
    s = '{RowOp, 5'd0, mode, idx, word, red, grn, blu, 1'b0, '0, '0, '0};
    return s;
  endfunction

  function automatic step_t show_row(input logic [63:0] eg, input logic [63:0] er,
                                     input logic [63:0] eb);
    step_t s;
    s = '{RowOp, 5'd0, lpse_pkg::ModeShow, 8'd0, 24'd0, 8'd0, 8'd0, 8'd0, 1'b1, eg, er, eb};
    return s;
  endfunction

  function automatic step_t count_row(input logic [4:0] v);
    step_t s;
    s = '{RowCount, v, 3'd0, 8'd0, 24'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0, '0, '0};
    return s;
  endfunction

  // updates the pixel store and queues the spi groups a show produces
  task automatic apply_pixel_op(input logic [2:0] mode, input logic [7:0] idx,
                                input logic [23:0] word, input logic [7:0] red,
                                input logic [7:0] grn, input logic [7:0] blu);
    int unsigned n;
    spi_group_t  e;
    n = lit_pixels();
    case (mode)
      lpse_pkg::ModeSetHex: begin
        if (idx < n) grb_store[idx] = {word[15:8], word[23:16], word[7:0]};
      end
      lpse_pkg::ModeSetParts: begin
        if (idx < n) grb_store[idx] = {grn, red, blu};
      end
      lpse_pkg::ModeFillRaw: begin
        for (int i = 0; i < n; i++) grb_store[i] = word;
      end
      lpse_pkg::ModeFillParts: begin
        for (int i = 0; i < n; i++) grb_store[i] = {grn, red, blu};
      end
      lpse_pkg::ModeShow: begin
        for (int i = 0; i < n; i++) begin
          for (int gi = 0; gi < 3; gi++) begin
            e.spi   = spi_word(grb_store[i][23-8*gi -: 8]);
            e.pixel = i[3:0];
            e.group = gi[1:0];
            e.last  = (i == n - 1) && (gi == 2);
            spi_words_due.push_back(e);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_op(input step_t s);
    int unsigned gap;
    spi_group_t  e;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= s.mode;
    s_axis_tdata_i  <= {s.blu, s.grn, s.red, s.word, s.idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_items++;
    if (s.mode == lpse_pkg::ModeShow) n_shows++;
    if (s.typed) begin
      for (int gi = 0; gi < 3; gi++) begin
        e.spi   = (gi == 0) ? s.exp_g : (gi == 1) ? s.exp_r : s.exp_b;
        e.pixel = 4'd0;
        e.group = gi[1:0];
        e.last  = (gi == 2);
        spi_words_due.push_back(e);
      end
    end else begin
      apply_pixel_op(s.mode, s.idx, s.word, s.red, s.grn, s.blu);
    end
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // the block may still be filling after the last result, so wait out its latency
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (spi_words_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    count_reg = v;
    n_counts++;
  endtask

  always @(posedge clk_i) begin
    if (pressure_req && !pressure_done) begin
      pressure_done = 1'b1;
      sink_wait     = LongHold;
    end
    if (sink_wait > 0) begin
      sink_wait--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      sink_wait = calm ? 0 : pick_gap();
    end
  end

  always @(posedge clk_i) begin
    spi_group_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (spi_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected spi item: spi %h pixel %0d group %0d last %b",
                   m_axis_tdata_o[63:0], m_axis_tdata_o[67:64],
                   m_axis_tdata_o[69:68], m_axis_tlast_o);
      end else begin
        e = spi_words_due.pop_front();
        if (m_axis_tdata_o[63:0] !== e.spi || m_axis_tdata_o[67:64] !== e.pixel ||
            m_axis_tdata_o[69:68] !== e.group || m_axis_tlast_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("spi item mismatch: expected %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                     e.spi, e.pixel, e.group, e.last,
                     m_axis_tdata_o[63:0], m_axis_tdata_o[67:64],
                     m_axis_tdata_o[69:68], m_axis_tlast_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d spi items still due",
               cycles, spi_words_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    step_t       steps [$];
    step_t       s;
    logic [4:0]  phase_counts [NumPhases];
    int unsigned n;
    int unsigned num_ops;
    int unsigned roll;

    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    calm            = 1'b0;
    pressure_req    = 1'b0;
    n_items         = 0;
    n_shows         = 0;
    n_counts        = 0;
    count_reg       = 5'd1;
    for (int i = 0; i < lpse_pkg::MaxPixels; i++) grb_store[i] = '0;

    // single pixel after reset, then each write mode read back by a show
    steps.push_back(show_row(AllZero, AllZero, AllZero));
    steps.push_back(op_row(lpse_pkg::ModeSetHex, 8'd0, 24'hFF0000, 8'h00, 8'h00, 8'h00));
    steps.push_back(show_row(AllZero, AllOne, AllZero));
    steps.push_back(op_row(lpse_pkg::ModeSetHex, 8'd1, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF));
    steps.push_back(op_row(lpse_pkg::ModeSetParts, 8'd0, 24'h000000, 8'h00, 8'hFF, 8'h00));
    steps.push_back(show_row(AllOne, AllZero, AllZero));
    steps.push_back(op_row(lpse_pkg::ModeFillRaw, 8'd0, 24'hFFFFFF, 8'h00, 8'h00, 8'h00));
    steps.push_back(show_row(AllOne, AllOne, AllOne));
    steps.push_back(op_row(lpse_pkg::ModeFillParts, 8'd0, 24'h000000, 8'h00, 8'h00, 8'hFF));
    steps.push_back(show_row(AllZero, AllZero, AllOne));
    steps.push_back(op_row(ModeUnused5, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00));
    steps.push_back(op_row(ModeUnused6, 8'd0, 24'hA5A5A5, 8'h5A, 8'hA5, 8'h5A));
    steps.push_back(op_row(ModeUnused7, 8'hFF, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF));
    // full chain, out of range indexes
    steps.push_back(count_row(5'd16));
    steps.push_back(op_row(lpse_pkg::ModeSetHex, 8'd15, 24'h5A3CC3, 8'h00, 8'h00, 8'h00));
    steps.push_back(op_row(lpse_pkg::ModeSetParts, 8'd16, 24'h000000, 8'hFF, 8'hFF, 8'hFF));
    steps.push_back(op_row(lpse_pkg::ModeSetHex, 8'hFF, 24'hFFFFFF, 8'h00, 8'h00, 8'h00));
    steps.push_back(op_row(lpse_pkg::ModeSetParts, 8'd3, 24'h000000, 8'h12, 8'h34, 8'h56));
    steps.push_back(op_row(lpse_pkg::ModeShow, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00));
    // empty chain does nothing
    steps.push_back(count_row(5'd0));
    steps.push_back(op_row(lpse_pkg::ModeFillRaw, 8'd0, 24'h123456, 8'h00, 8'h00, 8'h00));
    steps.push_back(op_row(lpse_pkg::ModeSetParts, 8'd0, 24'h000000, 8'h11, 8'h22, 8'h33));
    steps.push_back(op_row(lpse_pkg::ModeShow, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00));
    // count above the store size acts as full
    steps.push_back(count_row(5'd31));
    steps.push_back(op_row(lpse_pkg::ModeFillParts, 8'd0, 24'h000000, 8'hA5, 8'h0F, 8'hF0));
    steps.push_back(op_row(lpse_pkg::ModeShow, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00));
    // fill of a short chain keeps the entries beyond it
    steps.push_back(count_row(5'd2));
    steps.push_back(op_row(lpse_pkg::ModeFillRaw, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00));
    steps.push_back(count_row(5'd16));
    steps.push_back(op_row(lpse_pkg::ModeShow, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) begin
      if (steps[i].kind == RowCount) begin
        settle();
        write_count(steps[i].count);
      end else begin
        send_op(steps[i]);
      end
    end

    phase_counts = '{5'd3, 5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd2, 5'd16, 5'd12};
    phase_counts[5] = 5'($urandom_range(2, 15));
    phase_counts[8] = 5'($urandom_range(2, 15));

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      calm = (p % 3 == 2);
      write_count(phase_counts[p]);
      n = lit_pixels();
      num_ops = (n == 0) ? 12 : 38;
      if (p == 1) begin
        calm         = 1'b1;
        pressure_req = 1'b1;
      end
      for (int k = 0; k < num_ops; k++) begin
        roll = $urandom_range(0, 99);
        if (p == 1 && k < 8) s.mode = lpse_pkg::ModeShow;
        else if (roll < 25) s.mode = lpse_pkg::ModeSetHex;
        else if (roll < 45) s.mode = lpse_pkg::ModeSetParts;
        else if (roll < 55) s.mode = lpse_pkg::ModeFillRaw;
        else if (roll < 62) s.mode = lpse_pkg::ModeFillParts;
        else if (roll < 92) s.mode = lpse_pkg::ModeShow;
        else s.mode = 3'($urandom_range(ModeUnused5, ModeUnused7));
        if (n > 0 && $urandom_range(0, 99) < 80) s.idx = 8'($urandom_range(0, n - 1));
        else s.idx = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 9);
        s.word  = (roll == 0) ? 24'h000000 : (roll == 1) ? 24'hFFFFFF : 24'($urandom);
        s.red   = 8'($urandom);
        s.grn   = 8'($urandom);
        s.blu   = 8'($urandom);
        s.kind  = RowOp;
        s.typed = 1'b0;
        send_op(s);
      end
      if (p == 1) calm = 1'b0;
    end

    settle();

    $display("sent %0d items (%0d shows) across %0d pixel count settings",
             n_items, n_shows, n_counts);
    $display("checked %0d spi items, %0d mismatches", n_results, mismatches);
    if (mismatches == 0 && spi_words_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
